>>> hw/rtl/pmau_pkg.sv
package pmau_pkg;

  localparam int PAGE_BITS_DEF     = 12;
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int FRAME_COUNT_DEF   = 16;

  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_MAP   = 3'd2;
  localparam logic [2:0] OP_UNMAP = 3'd3;
  localparam logic [2:0] OP_ATTR  = 3'd4;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_RD_UNMAPPED = 4'd1;
  localparam logic [3:0] ST_RD_CROSS    = 4'd2;
  localparam logic [3:0] ST_RD_PERM     = 4'd3;
  localparam logic [3:0] ST_WR_UNMAPPED = 4'd4;
  localparam logic [3:0] ST_WR_CROSS    = 4'd5;
  localparam logic [3:0] ST_WR_PERM     = 4'd6;
  localparam logic [3:0] ST_MAPPED      = 4'd7;
  localparam logic [3:0] ST_NO_FRAME    = 4'd8;
  localparam logic [3:0] ST_ATTR_UNMAP  = 4'd9;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic lookup;     // resolve translation and decide
    logic mem_rd;     // issue byte read at current count
    logic mem_wr;     // write byte at current count
    logic rd_capture; // shift returned byte into read data
    logic zero_wr;    // write zero byte during page clear
    logic commit;     // update table and tlb after a successful map
    logic finish;     // register status and read data, with sign extension
  } pmau_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic do_read;
    logic do_write;
    logic do_zero;
    logic last_byte;
    logic last_zero;
  } pmau_sts_t;

endpackage

>>> hw/rtl/pmau_ram.sv
module pmau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pmau_ctrl.sv
module pmau_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pmau_pkg::pmau_sts_t sts,
  output pmau_pkg::pmau_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOOKUP = 7'b0000010,
    S_RD     = 7'b0000100,
    S_RDWAIT = 7'b0001000,
    S_WR     = 7'b0010000,
    S_ZERO   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (sts.do_read) begin
          state_nxt = S_RD;
        end else if (sts.do_write) begin
          state_nxt = S_WR;
        end else if (sts.do_zero) begin
          state_nxt = S_ZERO;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_RDWAIT;
      end
      S_RDWAIT: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = sts.last_byte ? S_DONE : S_RD;
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        if (sts.last_byte) begin
          state_nxt = S_DONE;
        end
      end
      S_ZERO: begin
        cmd.zero_wr = 1'b1;
        if (sts.last_zero) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_LOOKUP)
    else $error("load did not start lookup");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finish without result");

endmodule

>>> hw/rtl/pmau_dp.sv
module pmau_dp #(
  parameter int PAGE_BITS     = pmau_pkg::PAGE_BITS_DEF,
  parameter int TABLE_ENTRIES = pmau_pkg::TABLE_ENTRIES_DEF,
  parameter int FRAME_COUNT   = pmau_pkg::FRAME_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                big_endian,
  input  logic [2:0]          opcode,
  input  logic [63:0]         address,
  input  logic [1:0]          size_code,
  input  logic                sign_extend,
  input  logic [63:0]         write_data,
  input  logic                allow_read,
  input  logic                allow_write,
  input  pmau_pkg::pmau_cmd_t cmd,
  output pmau_pkg::pmau_sts_t sts,
  output logic [3:0]          status,
  output logic [63:0]         read_data
);

  localparam int TAG_W  = 64 - PAGE_BITS;
  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FR_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int MEM_D  = FRAME_COUNT << PAGE_BITS;
  localparam int MA_W   = FR_W + PAGE_BITS;

  logic [2:0]  op_r;
  logic [63:0] addr_r;
  logic [1:0]  size_r;
  logic        sx_r;
  logic [63:0] wdata_r;
  logic [1:0]  perms_r;

  logic [TABLE_ENTRIES-1:0] ent_valid_r;
  logic [TAG_W-1:0]         ent_tag_r   [TABLE_ENTRIES];
  logic [FR_W-1:0]          ent_frame_r [TABLE_ENTRIES];
  logic [1:0]               ent_perms_r [TABLE_ENTRIES];
  logic [FRAME_COUNT-1:0]   fr_used_r;
  logic                     tlb_valid_r;
  logic [TAG_W-1:0]         tlb_tag_r;
  logic [FR_W-1:0]          tlb_frame_r;
  logic [1:0]               tlb_perms_r;

  logic [FR_W-1:0]      xframe_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [3:0]           cnt_r;
  logic [PAGE_BITS-1:0] zcnt_r;
  logic [3:0]           status_r;
  logic [63:0]          rdata_r;

  logic [TAG_W-1:0] tag;
  assign tag = addr_r[63:PAGE_BITS];

  // table search
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic              free_slot_ok, free_fr_ok;
  logic [SLOT_W-1:0] free_slot;
  logic [FR_W-1:0]   free_fr;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (ent_valid_r[i] && ent_tag_r[i] == tag) begin
        hit = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
    free_slot_ok = 1'b0;
    free_slot = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!ent_valid_r[i]) begin
        free_slot_ok = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
    free_fr_ok = 1'b0;
    free_fr = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (!fr_used_r[i]) begin
        free_fr_ok = 1'b1;
        free_fr = FR_W'(i);
      end
    end
  end

  logic        tlb_hit, xl_ok;
  logic [1:0]  xl_perms;
  logic [FR_W-1:0] xl_frame;
  logic [63:0] span_end;
  logic        crosses, is_rd;
  logic [3:0]  nbytes_m1;

  always_comb begin
    tlb_hit   = tlb_valid_r && tlb_tag_r == tag;
    xl_ok     = tlb_hit || hit;
    xl_perms  = tlb_hit ? tlb_perms_r : ent_perms_r[hit_idx];
    xl_frame  = tlb_hit ? tlb_frame_r : ent_frame_r[hit_idx];
    nbytes_m1 = 4'((4'd1 << size_r) - 4'd1);
    span_end  = addr_r + 64'(nbytes_m1);
    crosses   = ((addr_r ^ span_end) >> PAGE_BITS) != '0 || span_end < addr_r;
    is_rd     = (op_r == pmau_pkg::OP_READ);
  end

  // frame memory
  logic [MA_W-1:0] ma;
  logic [MA_W-1:0] mem_addr;
  logic            mem_we;
  logic [7:0]      mem_wd, mem_rd;
  logic [3:0]      bsel;
  logic [5:0]      bsh;

  always_comb begin
    bsel = big_endian ? 4'(nbytes_m1 - cnt_r) : cnt_r;
    bsh  = {bsel[2:0], 3'b000};
    ma   = {xframe_r, addr_r[PAGE_BITS-1:0]} + MA_W'(cnt_r);
    if (cmd.zero_wr) begin
      mem_addr = {free_fr, zcnt_r};
    end else begin
      mem_addr = (32'(ma) < MEM_D) ? ma : '0;
    end
    mem_we = cmd.mem_wr || cmd.zero_wr;
    mem_wd = cmd.zero_wr ? 8'h00 : 8'(wdata_r >> bsh);
  end

  pmau_ram #(.WIDTH(8), .DEPTH(MEM_D)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wd),
    .raddr (mem_addr),
    .rdata (mem_rd)
  );

  logic [63:0] sx_val;
  always_comb begin
    sx_val = rdata_r;
    if (sx_r) begin
      case (size_r)
        2'd0:    sx_val = {{56{rdata_r[7]}}, rdata_r[7:0]};
        2'd1:    sx_val = {{48{rdata_r[15]}}, rdata_r[15:0]};
        2'd2:    sx_val = {{32{rdata_r[31]}}, rdata_r[31:0]};
        default: sx_val = rdata_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
      fr_used_r   <= '0;
      tlb_valid_r <= 1'b0;
      tlb_tag_r   <= '0;
      tlb_frame_r <= '0;
      tlb_perms_r <= '0;
    end else begin
      if (cmd.lookup) begin
        case (op_r)
          pmau_pkg::OP_READ, pmau_pkg::OP_WRITE: begin
            if (!tlb_hit && hit) begin
              tlb_valid_r <= 1'b1;
              tlb_tag_r   <= tag;
              tlb_frame_r <= ent_frame_r[hit_idx];
              tlb_perms_r <= ent_perms_r[hit_idx];
            end
          end
          pmau_pkg::OP_UNMAP: begin
            if (hit) begin
              fr_used_r[ent_frame_r[hit_idx]] <= 1'b0;
              ent_valid_r[hit_idx] <= 1'b0;
              tlb_valid_r <= 1'b0;
            end
          end
          pmau_pkg::OP_ATTR: begin
            if (hit) begin
              ent_perms_r[hit_idx] <= perms_r;
              tlb_valid_r <= 1'b1;
              tlb_tag_r   <= tag;
              tlb_frame_r <= ent_frame_r[hit_idx];
              tlb_perms_r <= perms_r;
            end
          end
          default: ;
        endcase
      end
      if (cmd.commit) begin
        fr_used_r[free_fr]     <= 1'b1;
        ent_valid_r[slot_r]    <= 1'b1;
        ent_tag_r[slot_r]      <= tag;
        ent_frame_r[slot_r]    <= free_fr;
        ent_perms_r[slot_r]    <= perms_r;
        tlb_valid_r            <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= opcode;
      addr_r   <= address;
      size_r   <= size_code;
      sx_r     <= sign_extend;
      wdata_r  <= write_data;
      perms_r  <= {allow_write, allow_read};
      cnt_r    <= '0;
      zcnt_r   <= '0;
      rdata_r  <= '0;
      status_r <= pmau_pkg::ST_OK;
    end
    if (cmd.lookup) begin
      xframe_r <= xl_frame;
      slot_r   <= free_slot;
      case (op_r)
        pmau_pkg::OP_READ, pmau_pkg::OP_WRITE: begin
          if (!xl_ok) begin
            status_r <= is_rd ? pmau_pkg::ST_RD_UNMAPPED : pmau_pkg::ST_WR_UNMAPPED;
          end else if (crosses) begin
            status_r <= is_rd ? pmau_pkg::ST_RD_CROSS : pmau_pkg::ST_WR_CROSS;
          end else if (!xl_perms[is_rd ? 0 : 1]) begin
            status_r <= is_rd ? pmau_pkg::ST_RD_PERM : pmau_pkg::ST_WR_PERM;
          end
        end
        pmau_pkg::OP_MAP: begin
          if (tlb_hit || hit) begin
            status_r <= pmau_pkg::ST_MAPPED;
          end else if (!free_slot_ok || !free_fr_ok) begin
            status_r <= pmau_pkg::ST_NO_FRAME;
          end
        end
        pmau_pkg::OP_ATTR: begin
          if (!hit) begin
            status_r <= pmau_pkg::ST_ATTR_UNMAP;
          end
        end
        default: ;
      endcase
    end
    if (cmd.rd_capture) begin
      rdata_r <= rdata_r | (64'(mem_rd) << bsh);
      cnt_r   <= cnt_r + 4'd1;
    end
    if (cmd.mem_wr) begin
      cnt_r <= cnt_r + 4'd1;
    end
    if (cmd.zero_wr) begin
      zcnt_r <= zcnt_r + PAGE_BITS'(1);
    end
    if (cmd.finish) begin
      status    <= status_r;
      read_data <= sx_val;
    end
  end

  assign sts.do_read   = (op_r == pmau_pkg::OP_READ) && xl_ok && !crosses && xl_perms[0];
  assign sts.do_write  = (op_r == pmau_pkg::OP_WRITE) && xl_ok && !crosses && xl_perms[1];
  assign sts.do_zero   = (op_r == pmau_pkg::OP_MAP) && !(tlb_hit || hit)
                         && free_slot_ok && free_fr_ok;
  assign sts.last_byte = (cnt_r == nbytes_m1);
  assign sts.last_zero = (zcnt_r == {PAGE_BITS{1'b1}});

  a_rd_status: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_rd |-> status_r == pmau_pkg::ST_OK)
    else $error("read issued after failed check");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_wr || cmd.rd_capture) |-> cnt_r <= nbytes_m1)
    else $error("byte count past access size");
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> free_slot_ok && free_fr_ok)
    else $error("commit without free slot or frame");

endmodule

>>> hw/rtl/paged_memory_access_unit_core.sv
// Paged memory for an emulated machine with a page table, a single-entry tlb and
// byte-wide frame memory. One beat is taken at a time. A read or write moves its bytes
// one at a time through the single byte port of the frame memory, a read issuing each
// byte and then capturing it; a map that succeeds clears the new frame one byte per
// cycle. A result waiting in the output register does not stop the next beat from
// being taken.
module paged_memory_access_unit_core #(
  parameter int PAGE_BITS     = pmau_pkg::PAGE_BITS_DEF,
  parameter int TABLE_ENTRIES = pmau_pkg::TABLE_ENTRIES_DEF,
  parameter int FRAME_COUNT   = pmau_pkg::FRAME_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[2:0], address[66:3], size_code[68:67], sign_extend[69],
  // write_data[133:70], allow_read[134], allow_write[135]
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[3:0], read_data[67:4]
  output logic [71:0]  out_tdata
);

  logic                big_endian_r;
  logic                in_fire;
  pmau_pkg::pmau_cmd_t cmd;
  pmau_pkg::pmau_sts_t sts;
  logic [3:0]          status;
  logic [63:0]         read_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
    end else if (cfg_we) begin
      big_endian_r <= cfg_wdata;
    end
  end

  assign in_fire = in_tvalid && in_tready;

  pmau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pmau_dp #(
    .PAGE_BITS     (PAGE_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FRAME_COUNT   (FRAME_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .big_endian  (big_endian_r),
    .opcode      (in_tdata[2:0]),
    .address     (in_tdata[66:3]),
    .size_code   (in_tdata[68:67]),
    .sign_extend (in_tdata[69]),
    .write_data  (in_tdata[133:70]),
    .allow_read  (in_tdata[134]),
    .allow_write (in_tdata[135]),
    .cmd         (cmd),
    .sts         (sts),
    .status      (status),
    .read_data   (read_data)
  );

  assign out_tdata = {4'b0000, read_data, status};

endmodule
